// ----- sv/ltcd_pkg.sv -----
// Shared types, constants and brightness curve for the two-channel pulse splitter.
`default_nettype none
package ltcd_pkg;
   localparam int TableSlots = 32;
   localparam logic [31:0] SnapBright = 32'd240;
   localparam logic [31:0] SnapWindow = 32'd160;

   typedef enum logic [1:0] {
      CSR_MIX_MODE    = 2'd0,
      CSR_INPUT_LIMIT = 2'd1,
      CSR_FULL_SCALE  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCALE1,
      ST_SCALE2,
      ST_SEARCH,
      ST_LERP_P,
      ST_LERP_T,
      ST_SNAP,
      ST_SPLIT,
      ST_HOLD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [13:0] x;
      logic [11:0] pulse;
      logic [14:0] period;
   } anchor_type;

   function automatic anchor_type curve_at(input logic [4:0] i);
      anchor_type a;
      case (i)
         5'd0:    a = '{14'd12,    12'd24,   15'd24000};
         5'd1:    a = '{14'd24,    12'd48,   15'd24000};
         5'd2:    a = '{14'd36,    12'd72,   15'd24000};
         5'd3:    a = '{14'd60,    12'd120,  15'd24000};
         5'd4:    a = '{14'd120,   12'd240,  15'd24000};
         5'd5:    a = '{14'd240,   12'd480,  15'd24000};
         5'd6:    a = '{14'd300,   12'd600,  15'd24000};
         5'd7:    a = '{14'd360,   12'd600,  15'd20000};
         5'd8:    a = '{14'd600,   12'd600,  15'd12000};
         5'd9:    a = '{14'd960,   12'd600,  15'd7500};
         5'd10:   a = '{14'd1200,  12'd600,  15'd6000};
         5'd11:   a = '{14'd1440,  12'd600,  15'd5000};
         5'd12:   a = '{14'd1920,  12'd600,  15'd3750};
         5'd13:   a = '{14'd2400,  12'd600,  15'd3000};
         5'd14:   a = '{14'd2765,  12'd692,  15'd3000};
         5'd15:   a = '{14'd10800, 12'd2700, 15'd3000};
         5'd16:   a = '{14'd11400, 12'd2850, 15'd3000};
         default: a = '{14'd12000, 12'd3000, 15'd3000};
      endcase
      return a;
   endfunction
endpackage
`default_nettype wire

// ----- sv/ltcd_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module ltcd_div
   import ltcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [31:0]      quotient
);
   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff[15:0], quot_ff[31]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 6'd32;
         dsr_in  = divisor;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = start || (cnt_ff != 6'd0);
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// ----- sv/led_two_channel_dim_pulse_split.sv -----
// Top level: two-channel LED dimmer pulse splitter.
// Operation: up to five divides on one shared divider plus a search of the curve
// anchors.
// Throughput: one word at a time; req_stall is high from acceptance until the result
// word is registered, longer while a previous result is still stalled.
// Reset: synchronous; registers return to 0 / 12000 / 12000, held state clears.
`default_nettype none
module led_two_channel_dim_pulse_split
   import ltcd_pkg::*;
#(
   parameter int NUM_ANCHORS = 18
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [13:0] req_level_one,
   input  wire logic [13:0] req_level_two,
   input  wire logic [15:0] req_current_period,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [14:0]      rsp_pulse_one,
   output logic [14:0]      rsp_pulse_two,
   output logic [15:0]      rsp_period_out,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);
   localparam logic [4:0] Last = 5'(NUM_ANCHORS - 1);

   state_type   state_ff, state_in;
   logic        mode_ff;
   logic [14:0] limit_ff;
   logic [13:0] fs_ff;
   logic [13:0] hl1_ff, hl1_in, hl2_ff, hl2_in;
   logic [14:0] hp1_ff, hp1_in, hp2_ff, hp2_in;
   logic [13:0] l1_ff, l1_in, l2_ff, l2_in;
   logic [15:0] cur_ff, cur_in;
   logic [14:0] bright_ff, bright_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] period_ff, period_in;
   logic [4:0]  idx_ff, idx_in;
   logic        issued_ff, issued_in;
   logic [15:0] p1_ff, p1_in;
   logic [14:0] p2_ff, p2_in;
   logic [14:0] o1_ff, o1_in, o2_ff, o2_in;
   logic [15:0] op_ff, op_in;

   logic        dv_start, dv_busy;
   logic [31:0] dv_dividend, dv_quot;
   logic [15:0] dv_divisor;

   ltcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (dv_divisor),
      .busy     (dv_busy),
      .quotient (dv_quot)
   );

   anchor_type a_lo, a_hi, a_first, a_last;
   logic [14:0] sum_raw, sum_lim;
   logic [15:0] span, off, dy_p, dy_t;
   logic        up_t;
   logic [13:0] fs_eff;
   logic [16:0] diff;
   logic        r1, r2;
   logic [15:0] p1w, p2w;

   always_comb begin
      a_lo    = curve_at(idx_ff - 5'd1);
      a_hi    = curve_at(idx_ff);
      a_first = curve_at(5'd0);
      a_last  = curve_at(Last);
      sum_raw = {1'b0, req_level_one} + {1'b0, req_level_two};
      sum_lim = {1'b0, l1_ff} + {1'b0, l2_ff};
      span    = {2'b0, a_hi.x} - {2'b0, a_lo.x};
      off     = {1'b0, bright_ff} - {2'b0, a_lo.x};
      dy_p    = {4'b0, a_hi.pulse} - {4'b0, a_lo.pulse};
      up_t    = a_hi.period >= a_lo.period;
      dy_t    = up_t ? {1'b0, a_hi.period} - {1'b0, a_lo.period}
                     : {1'b0, a_lo.period} - {1'b0, a_hi.period};
      fs_eff  = (fs_ff == 14'd0) ? 14'd1 : fs_ff;
      diff    = (period_ff >= cur_ff) ? {1'b0, period_ff} - {1'b0, cur_ff}
                                      : {1'b0, cur_ff} - {1'b0, period_ff};
      if (mode_ff) begin
         r1 = (l1_ff != 14'd0) && (l2_ff != 14'd0);
         r2 = (l1_ff != 14'd0) && (l2_ff < fs_eff);
      end else begin
         r1 = l1_ff != 14'd0;
         r2 = l2_ff != 14'd0;
      end
      p1w = p1_ff;
      p2w = {1'b0, p2_ff};
   end

   always_comb begin
      state_in    = state_ff;
      hl1_in = hl1_ff; hl2_in = hl2_ff; hp1_in = hp1_ff; hp2_in = hp2_ff;
      l1_in = l1_ff; l2_in = l2_ff; cur_in = cur_ff;
      bright_in = bright_ff; total_in = total_ff; period_in = period_ff;
      idx_in = idx_ff; issued_in = 1'b0;
      p1_in = p1_ff; p2_in = p2_ff;
      o1_in = o1_ff; o2_in = o2_ff; op_in = op_ff;
      dv_start    = 1'b0;
      dv_dividend = '0;
      dv_divisor  = 16'd1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_current_period;
               l1_in  = req_level_one;
               l2_in  = req_level_two;
               idx_in = 5'd1;
               if (mode_ff) begin
                  if ({1'b0, req_level_one} > limit_ff) begin
                     l1_in = limit_ff[13:0];
                  end
                  bright_in = ({1'b0, req_level_one} > limit_ff) ? limit_ff
                                                                 : {1'b0, req_level_one};
                  state_in = ST_SEARCH;
               end else if (sum_raw >= limit_ff) begin
                  bright_in = limit_ff;
                  state_in  = ST_SCALE1;
                  if (sum_raw == 15'd0) begin
                     l1_in = '0; l2_in = '0;
                     state_in = ST_SEARCH;
                  end
               end else begin
                  bright_in = sum_raw;
                  state_in  = ST_SEARCH;
               end
               issued_in = 1'b0;
            end
         end
         ST_SCALE1: begin
            dv_divisor  = {1'b0, {1'b0, l1_ff} + {1'b0, l2_ff}};
            dv_dividend = 32'(l1_ff) * 32'(limit_ff);
            if (!issued_ff) begin
               dv_start = 1'b1; issued_in = 1'b1;
            end else if (!dv_busy) begin
               p1_in = dv_quot[15:0];
               state_in = ST_SCALE2;
            end else begin
               issued_in = 1'b1;
            end
         end
         ST_SCALE2: begin
            dv_divisor  = {1'b0, {1'b0, l1_ff} + {1'b0, l2_ff}};
            dv_dividend = 32'(l2_ff) * 32'(limit_ff);
            if (!issued_ff) begin
               dv_start = 1'b1; issued_in = 1'b1;
            end else if (!dv_busy) begin
               l1_in = p1_ff[13:0];
               l2_in = dv_quot[13:0];
               state_in = ST_SEARCH;
            end else begin
               issued_in = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (bright_ff == 15'd0) begin
               total_in = '0; period_in = {1'b0, a_first.period};
               state_in = ST_SNAP;
            end else if (bright_ff <= {1'b0, a_first.x}) begin
               total_in = {4'b0, a_first.pulse}; period_in = {1'b0, a_first.period};
               state_in = ST_SNAP;
            end else if (bright_ff >= {1'b0, a_last.x} || idx_ff > Last) begin
               total_in = {4'b0, a_last.pulse}; period_in = {1'b0, a_last.period};
               state_in = ST_SNAP;
            end else if (bright_ff <= {1'b0, a_hi.x}) begin
               if (a_hi.x <= a_lo.x) begin
                  total_in = {4'b0, a_lo.pulse}; period_in = {1'b0, a_lo.period};
                  state_in = ST_SNAP;
               end else begin
                  state_in = ST_LERP_P;
               end
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ST_LERP_P: begin
            dv_divisor  = span;
            dv_dividend = 32'(dy_p) * 32'(off) + 32'(span[15:1]);
            if (!issued_ff) begin
               dv_start = 1'b1; issued_in = 1'b1;
            end else if (!dv_busy) begin
               total_in = {4'b0, a_lo.pulse} + dv_quot[15:0];
               state_in = ST_LERP_T;
            end else begin
               issued_in = 1'b1;
            end
         end
         ST_LERP_T: begin
            dv_divisor  = span;
            dv_dividend = 32'(dy_t) * 32'(off) + 32'(span[15:1]);
            if (!issued_ff) begin
               dv_start = 1'b1; issued_in = 1'b1;
            end else if (!dv_busy) begin
               period_in = up_t ? {1'b0, a_lo.period} + dv_quot[15:0]
                                : {1'b0, a_lo.period} - dv_quot[15:0];
               state_in = ST_SNAP;
            end else begin
               issued_in = 1'b1;
            end
         end
         ST_SNAP: begin
            if ({17'b0, bright_ff} <= SnapBright && {15'b0, diff} < SnapWindow) begin
               period_in = cur_ff;
            end
            p1_in = '0; p2_in = '0;
            if (mode_ff || sum_lim != 15'd0) begin
               state_in = ST_SPLIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SPLIT: begin
            if (mode_ff) begin
               dv_divisor  = {2'b0, fs_eff};
               dv_dividend = 32'(total_ff) * 32'(l2_ff) + 32'(fs_eff[13:1]);
            end else begin
               dv_divisor  = {1'b0, sum_lim};
               dv_dividend = 32'(total_ff) * 32'(l1_ff) + 32'(sum_lim[14:1]);
            end
            if (!issued_ff) begin
               dv_start = 1'b1; issued_in = 1'b1;
            end else if (!dv_busy) begin
               // saturate: anything past 16 bits is beyond any period
               p1_in = (dv_quot > 32'h0000_FFFF) ? 16'hFFFF : dv_quot[15:0];
               if (dv_quot > 32'(total_ff)) begin
                  p2_in = '0;
               end else begin
                  p2_in = 15'(total_ff - dv_quot[15:0]);
               end
               state_in = mode_ff ? ST_OUT : ST_HOLD;
            end else begin
               issued_in = 1'b1;
            end
         end
         ST_HOLD: begin
            if (l1_ff <= hl1_ff && p1_ff >= {1'b0, hp1_ff}) begin
               p1_in = {1'b0, hp1_ff};
            end else begin
               hl1_in = l1_ff; hp1_in = p1_ff[14:0];
            end
            if (l2_ff <= hl2_ff && p2_ff >= hp2_ff) begin
               p2_in = hp2_ff;
            end else begin
               hl2_in = l2_ff; hp2_in = p2_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (p1w > period_ff)            o1_in = period_ff[14:0];
            else if (r1 && p1_ff == 16'd0)  o1_in = 15'd1;
            else                            o1_in = p1_ff[14:0];
            if (p2w > period_ff)            o2_in = period_ff[14:0];
            else if (r2 && p2_ff == 15'd0)  o2_in = 15'd1;
            else                            o2_in = p2_ff;
            op_in    = period_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic rsp_valid_ff, rsp_valid_in;
   logic out_busy;
   assign out_busy     = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in = (state_ff == ST_OUT) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   state_type state_gated;
   assign state_gated = (state_ff == ST_OUT && out_busy) ? ST_OUT : state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         limit_ff     <= 15'd12000;
         fs_ff        <= 14'd12000;
         hl1_ff <= '0; hl2_ff <= '0; hp1_ff <= '0; hp2_ff <= '0;
         issued_ff    <= 1'b0;
      end else begin
         state_ff     <= state_gated;
         rsp_valid_ff <= out_busy ? 1'b1 : rsp_valid_in;
         issued_ff    <= issued_in;
         hl1_ff <= hl1_in; hl2_ff <= hl2_in; hp1_ff <= hp1_in; hp2_ff <= hp2_in;
         if (csr_write) begin
            case (csr_index)
               CSR_MIX_MODE:    mode_ff  <= csr_data[0];
               CSR_INPUT_LIMIT: limit_ff <= csr_data;
               CSR_FULL_SCALE:  fs_ff    <= csr_data[13:0];
               default: ;
            endcase
         end
      end
      l1_ff <= l1_in; l2_ff <= l2_in; cur_ff <= cur_in;
      bright_ff <= bright_in; total_ff <= total_in; period_ff <= period_in;
      idx_ff <= idx_in; p1_ff <= p1_in; p2_ff <= p2_in;
      if (!out_busy) begin
         o1_ff <= o1_in; o2_ff <= o2_in; op_ff <= op_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pulse_one  = o1_ff;
   assign rsp_pulse_two  = o2_ff;
   assign rsp_period_out = op_ff;

   a_out_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_pulse_one} <= rsp_period_out))
      else $error("pulse one beyond period");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("ready while busy");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_period_out)))
      else $error("result changed while stalled");
endmodule
`default_nettype wire

// ----- sim/led_two_channel_dim_pulse_split_tb.sv -----
// Testbench for the two-channel LED pulse splitter: predicts pulses and period per word.
`timescale 1ns / 100ps
module led_two_channel_dim_pulse_split_tb;
   import ltcd_pkg::*;

   typedef struct {
      logic [13:0] level_one;
      logic [13:0] level_two;
      logic [15:0] cur_period;
   } level_word_t;

   typedef struct {
      logic [14:0] pulse_one;
      logic [14:0] pulse_two;
      logic [15:0] period;
   } pulse_word_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [13:0] req_level_one = 0;
   logic [13:0] req_level_two = 0;
   logic [15:0] req_current_period = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [14:0] rsp_pulse_one;
   logic [14:0] rsp_pulse_two;
   logic [15:0] rsp_period_out;
   logic csr_write = 0;
   csr_index_type csr_index = CSR_MIX_MODE;
   logic [14:0] csr_data = 0;

   led_two_channel_dim_pulse_split u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_level_one(req_level_one), .req_level_two(req_level_two),
      .req_current_period(req_current_period),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pulse_one(rsp_pulse_one), .rsp_pulse_two(rsp_pulse_two),
      .rsp_period_out(rsp_period_out),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   bit          cct_mode;
   int unsigned limit_val;
   int unsigned scale_val;
   int unsigned held_l1, held_p1, held_l2, held_p2;

   level_word_t pending_words[$];
   pulse_word_t expected_pulses[$];
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int checked = 0;
   longint cycles = 0;

   int unsigned anc_x[18] = '{12, 24, 36, 60, 120, 240, 300, 360, 600, 960, 1200, 1440,
                             1920, 2400, 2765, 10800, 11400, 12000};
   int unsigned anc_p[18] = '{24, 48, 72, 120, 240, 480, 600, 600, 600, 600, 600, 600,
                             600, 600, 692, 2700, 2850, 3000};
   int unsigned anc_t[18] = '{24000, 24000, 24000, 24000, 24000, 24000, 24000, 20000,
                             12000, 7500, 6000, 5000, 3750, 3000, 3000, 3000, 3000, 3000};

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned interp(int unsigned x, int unsigned x0, int unsigned y0,
                                          int unsigned x1, int unsigned y1);
      int unsigned span;
      span = x1 - x0;
      if (x1 <= x0) return y0;
      if (y1 >= y0) return y0 + ((y1 - y0) * (x - x0) + span / 2) / span;
      return y0 - ((y0 - y1) * (x - x0) + span / 2) / span;
   endfunction

   function automatic int unsigned clamp_pulse(int unsigned p, int unsigned per, bit req);
      if (p > per) return per;
      if (req && p == 0) return 1;
      return p;
   endfunction

   function automatic pulse_word_t predict_pulses(level_word_t w);
      pulse_word_t r;
      int unsigned l1, l2, cur, bright, total, per, sum, p1, p2, fs, diff;
      bit r1, r2, found;
      l1 = w.level_one; l2 = w.level_two; cur = w.cur_period;
      p1 = 0; p2 = 0; found = 0;
      if (cct_mode) begin
         if (l1 > limit_val) l1 = limit_val;
         bright = l1;
      end else begin
         sum = l1 + l2;
         bright = sum;
         if (sum >= limit_val) begin
            bright = limit_val;
            if (sum != 0) begin
               l1 = l1 * limit_val / sum;
               l2 = l2 * limit_val / sum;
            end else begin
               l1 = 0; l2 = 0;
            end
         end
      end
      if (bright == 0) begin
         total = 0; per = anc_t[0];
      end else if (bright <= anc_x[0]) begin
         total = anc_p[0]; per = anc_t[0];
      end else begin
         total = anc_p[17]; per = anc_t[17];
         if (bright < anc_x[17])
            for (int i = 1; i < 18 && !found; i++)
               if (bright <= anc_x[i]) begin
                  total = interp(bright, anc_x[i-1], anc_p[i-1], anc_x[i], anc_p[i]);
                  per = interp(bright, anc_x[i-1], anc_t[i-1], anc_x[i], anc_t[i]);
                  found = 1;
               end
      end
      diff = (per >= cur) ? per - cur : cur - per;
      if (bright <= 240 && diff < 160) per = cur;
      if (cct_mode) begin
         fs = (scale_val == 0) ? 1 : scale_val;
         r1 = (l1 > 0) && (l2 > 0);
         r2 = (l1 > 0) && (l2 < fs);
         p1 = (total * l2 + fs / 2) / fs;
         p2 = (p1 > total) ? 0 : total - p1;
      end else begin
         r1 = l1 > 0;
         r2 = l2 > 0;
         sum = l1 + l2;
         if (sum != 0) begin
            p1 = (total * l1 + sum / 2) / sum;
            p2 = total - p1;
            if (l1 <= held_l1 && p1 >= held_p1) p1 = held_p1;
            else begin
               held_l1 = l1; held_p1 = p1;
            end
            if (l2 <= held_l2 && p2 >= held_p2) p2 = held_p2;
            else begin
               held_l2 = l2; held_p2 = p2;
            end
         end
      end
      r.pulse_one = 15'(clamp_pulse(p1, per, r1));
      r.pulse_two = 15'(clamp_pulse(p2, per, r2));
      r.period = 16'(per);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               level_word_t w;
               w = pending_words.pop_front();
               expected_pulses.push_back(predict_pulses(w));
               req_valid <= 1;
               req_level_one <= w.level_one;
               req_level_two <= w.level_two;
               req_current_period <= w.cur_period;
            end else begin
               req_valid <= 0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         checked <= checked + 1;
         if (expected_pulses.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("ERROR: unexpected word %0d/%0d/%0d",
                        rsp_pulse_one, rsp_pulse_two, rsp_period_out);
         end else begin
            pulse_word_t e;
            e = expected_pulses.pop_front();
            if (e.pulse_one !== rsp_pulse_one || e.pulse_two !== rsp_pulse_two ||
                e.period !== rsp_period_out) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("ERROR: exp p1=%0d p2=%0d per=%0d got p1=%0d p2=%0d per=%0d",
                           e.pulse_one, e.pulse_two, e.period,
                           rsp_pulse_one, rsp_pulse_two, rsp_period_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 2000000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic add_word(int unsigned l1, int unsigned l2, int unsigned cp);
      level_word_t w;
      w.level_one = 14'(l1); w.level_two = 14'(l2); w.cur_period = 16'(cp);
      pending_words.push_back(w);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= 15'(val);
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_MIX_MODE:    cct_mode = val[0];
         CSR_INPUT_LIMIT: limit_val = val;
         default:         scale_val = val;
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_pulses.size() > 0 || req_valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // random word; mostly in range, some raw bit patterns
   task automatic add_random(int n);
      repeat (n) begin
         int unsigned a, b, cp;
         case ($urandom_range(5))
            0: begin a = $urandom_range(300); b = $urandom_range(300); end
            1: begin a = $urandom_range(16383); b = $urandom_range(16383); end
            2: begin a = $urandom_range(3000); b = $urandom_range(3000); end
            default: begin a = $urandom_range(12000); b = $urandom_range(12000); end
         endcase
         cp = ($urandom_range(1)) ? $urandom_range(65535) : 24000 + $urandom_range(320) - 160;
         add_word(a, b, cp);
      end
   endtask

   initial begin
      cct_mode = 0; limit_val = 12000; scale_val = 12000;
      held_l1 = 0; held_p1 = 0; held_l2 = 0; held_p2 = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed
      add_word(0, 0, 0);
      add_word(0, 0, 24100);
      add_word(5, 0, 23900);
      add_word(12000, 12000, 65535);
      add_word(16383, 16383, 0);
      add_word(6000, 6000, 3000);
      add_word(100, 140, 24159);
      add_word(120, 121, 24160);
      add_word(3000, 100, 3000);
      add_word(2000, 100, 3000);
      add_word(2000, 3000, 3000);
      add_word(1, 11999, 3000);
      drain();
      write_reg(CSR_MIX_MODE, 1);
      add_word(12000, 6000, 3000);
      add_word(12000, 0, 3000);
      add_word(12000, 12000, 3000);
      add_word(16383, 16383, 3000);
      add_word(0, 5000, 3000);
      add_word(200, 1, 24100);
      drain();
      write_reg(CSR_FULL_SCALE, 0);
      add_word(3000, 1, 100);
      add_word(3000, 0, 100);
      drain();
      write_reg(CSR_MIX_MODE, 0);
      write_reg(CSR_INPUT_LIMIT, 0);
      add_word(500, 700, 3000);
      add_word(0, 0, 3000);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_MIX_MODE, ph % 3 == 1);
         case (ph % 4)
            0: write_reg(CSR_INPUT_LIMIT, 12000);
            1: write_reg(CSR_INPUT_LIMIT, 24000);
            2: write_reg(CSR_INPUT_LIMIT, 1);
            default: write_reg(CSR_INPUT_LIMIT, $urandom_range(1, 32767));
         endcase
         case (ph % 3)
            0: write_reg(CSR_FULL_SCALE, 12000);
            1: write_reg(CSR_FULL_SCALE, 1 + $urandom_range(16382));
            default: write_reg(CSR_FULL_SCALE, 1);
         endcase
         case (ph % 4)
            0: begin sender_idle_pct = 0; stall_pct = 0; end
            1: begin sender_idle_pct = 46; stall_pct = 0; end
            2: begin sender_idle_pct = 0; stall_pct = 46; end
            default: begin sender_idle_pct = 23; stall_pct = 23; end
         endcase
         add_random(178);
         drain();
      end

      $display("Ran %0d words over direct and CCT modes, several limits and scales.", checked);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
